### rtl/core/hilidx_pkg.sv
// ----------------------------------------------------------------------------
// hilidx_pkg
// Shared types, constants and quadrant tables for the 2-D Hilbert index core.
// ----------------------------------------------------------------------------
package hilidx_pkg;

    localparam int COORD_W           = 32;
    localparam int ORDER_W           = 6;
    localparam int INDEX_W           = 64;
    localparam int DEFAULT_MAX_ORDER = 32;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd16;

    // per-point state handed from cell to cell
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ORDER_W-1:0] lv;
        logic [1:0]         rot;
        logic               rev;
        logic               oor;
    } cell_state_t;

    // quadrant from rotation and the x and y bits of one level
    function automatic logic [1:0] quad_of(input logic [1:0] rot, input logic xb,
                                           input logic yb);
        logic [1:0] q;
        case ({rot, xb, yb})
            4'b00_00: q = 2'd0;
            4'b00_01: q = 2'd1;
            4'b00_10: q = 2'd3;
            4'b00_11: q = 2'd2;
            4'b01_00: q = 2'd1;
            4'b01_01: q = 2'd2;
            4'b01_10: q = 2'd0;
            4'b01_11: q = 2'd3;
            4'b10_00: q = 2'd2;
            4'b10_01: q = 2'd3;
            4'b10_10: q = 2'd1;
            4'b10_11: q = 2'd0;
            4'b11_00: q = 2'd3;
            4'b11_01: q = 2'd0;
            4'b11_10: q = 2'd2;
            default:  q = 2'd1;
        endcase
        return q;
    endfunction

    // rotation advance per quadrant
    function automatic logic [1:0] rot_step(input logic [1:0] q);
        logic [1:0] s;
        case (q)
            2'd0:    s = 2'd3;
            2'd3:    s = 2'd1;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

    // quadrants that reverse the sense
    function automatic logic sense_flip(input logic [1:0] q);
        return (q == 2'd0) || (q == 2'd3);
    endfunction

endpackage

### rtl/core/hilidx_cell.sv
// ----------------------------------------------------------------------------
// hilidx_cell
// One bit level of the Hilbert walk: picks the quadrant, adds its digit to the
// index and passes the updated rotation and sense to the next cell.
// ----------------------------------------------------------------------------
module hilidx_cell
    import hilidx_pkg::*;
#(
    parameter int MAX_ORDER = DEFAULT_MAX_ORDER,
    parameter int LEVEL     = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  cell_state_t            in_st,
    input  logic [2*MAX_ORDER-1:0] in_idx,
    output logic                   out_valid,
    output cell_state_t            out_st,
    output logic [2*MAX_ORDER-1:0] out_idx
);

    logic                   valid_reg;
    cell_state_t            st_reg,  st_next;
    logic [2*MAX_ORDER-1:0] idx_reg, idx_next;
    logic                   active;
    logic [1:0]             q;
    logic [1:0]             w;

    assign active = !in_st.oor && (6'(LEVEL) < in_st.lv);
    assign q      = quad_of(in_st.rot, in_st.x[LEVEL], in_st.y[LEVEL]);
    assign w      = in_st.rev ? (2'd3 - q) : q;

    always_comb begin
        st_next  = in_st;
        idx_next = in_idx;
        if (active) begin
            idx_next[2*LEVEL +: 2] = w;
            st_next.rot            = in_st.rot + rot_step(q);
            st_next.rev            = in_st.rev ^ sense_flip(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_idx   = idx_reg;

endmodule

### rtl/core/hilbert_index_2d.sv
// ----------------------------------------------------------------------------
// hilbert_index_2d
// Maps a point (x, y) on a 2^order square grid to its Hilbert curve position.
// ----------------------------------------------------------------------------
// Points enter on the s_ channel, x in s_tdata[31:0] and y in s_tdata[63:32].
// Each point leaves on the m_ channel with its curve position in m_tdata and
// an out-of-range flag in m_tuser; a flagged point carries position zero.
// The grid order is written through cfg_wen / cfg_wdata while the core is idle;
// orders above MAX_ORDER are clamped to MAX_ORDER.
// The core is a row of MAX_ORDER cells, one per bit level from the top level
// down, each registering the point as it passes, and one point is taken every
// cycle while the receiver does not stall.
// The last cell doubles as the output register. When the receiver stalls,
// the whole row holds and s_tready falls, so nothing is lost or repeated.
// Reset empties the row and sets the order to 16.
// ----------------------------------------------------------------------------
module hilbert_index_2d
    import hilidx_pkg::*;
#(
    parameter int MAX_ORDER = DEFAULT_MAX_ORDER
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [ORDER_W-1:0]   cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2*COORD_W-1:0] s_tdata,   // coord_x, coord_y
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [INDEX_W-1:0]   m_tdata,   // curve_index
    output logic                 m_tuser    // out_of_range
);

    logic [ORDER_W-1:0]     order_reg;
    logic [ORDER_W-1:0]     lv;
    logic [COORD_W-1:0]     cx;
    logic [COORD_W-1:0]     cy;
    logic                   en;

    logic                   stg_valid [MAX_ORDER+1];
    cell_state_t            stg_st    [MAX_ORDER+1];
    logic [2*MAX_ORDER-1:0] stg_idx   [MAX_ORDER+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_RESET;
        end else if (cfg_wen) begin
            order_reg <= cfg_wdata;
        end
    end

    assign lv = (order_reg > 6'(MAX_ORDER)) ? 6'(MAX_ORDER) : order_reg;
    assign cx = s_tdata[COORD_W-1:0];
    assign cy = s_tdata[2*COORD_W-1:COORD_W];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && aresetn;

    assign stg_valid[0]  = s_tvalid;
    assign stg_st[0].x   = cx;
    assign stg_st[0].y   = cy;
    assign stg_st[0].lv  = lv;
    assign stg_st[0].rot = 2'd0;
    assign stg_st[0].rev = 1'b0;
    assign stg_st[0].oor = ((cx >> lv) != '0) || ((cy >> lv) != '0);
    assign stg_idx[0]    = '0;

    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
        hilidx_cell #(
            .MAX_ORDER (MAX_ORDER),
            .LEVEL     (MAX_ORDER - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (stg_valid[k]),
            .in_st     (stg_st[k]),
            .in_idx    (stg_idx[k]),
            .out_valid (stg_valid[k+1]),
            .out_st    (stg_st[k+1]),
            .out_idx   (stg_idx[k+1])
        );
    end

    assign m_tvalid = stg_valid[MAX_ORDER];
    assign m_tdata  = INDEX_W'(stg_idx[MAX_ORDER]);
    assign m_tuser  = stg_st[MAX_ORDER].oor;

endmodule
